// ===== rtl/cfol_pkg.sv =====
`timescale 1ns / 1ps

package cfol_pkg;

   localparam int MAX_STAGES_DEFAULT = 8;

   localparam int SAMPLE_W  = 16;
   localparam int ELAPSED_W = 24;
   localparam int VALUE_W   = 32;
   localparam int ALPHA_W   = 17;
   localparam int RC_W      = 24;
   localparam int STAGES_W  = 4;
   localparam int REQ_DATA_W = 48;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
   localparam int DIV_STEPS = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIXED_ALPHA   = 2'd0,
      CSR_RC_TIME_US    = 2'd1,
      CSR_STAGES_IN_USE = 2'd2
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_FILTER = 1'b0,
      OP_LOAD   = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_READ,
      S_MULT,
      S_WRITE,
      S_FREAD,
      S_FOUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_all;
      logic div_start;
      logic div_step;
      logic rd_en;
      logic rd_last;
      logic mult;
      logic write;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic op_load;
      logic rc_mode;
      logic hold;
      logic div_done;
      logic last_stage;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/cfol_ctrl.sv =====
`timescale 1ns / 1ps

module cfol_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  cfol_pkg::status_type status,
   output cfol_pkg::cmd_type    cmd
);

   cfol_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfol_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         cfol_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = cfol_pkg::S_DECODE;
            end
         end
         cfol_pkg::S_DECODE: begin
            priority if (status.op_load) begin
               cmd.load_all = 1'b1;
               state_in     = cfol_pkg::S_FREAD;
            end else if (status.hold) begin
               state_in = cfol_pkg::S_FREAD;
            end else if (status.rc_mode) begin
               cmd.div_start = 1'b1;
               state_in      = cfol_pkg::S_DIV;
            end else begin
               state_in = cfol_pkg::S_READ;
            end
         end
         cfol_pkg::S_DIV: begin
            if (status.div_done) begin
               state_in = cfol_pkg::S_READ;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         cfol_pkg::S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = cfol_pkg::S_MULT;
         end
         cfol_pkg::S_MULT: begin
            cmd.mult = 1'b1;
            state_in = cfol_pkg::S_WRITE;
         end
         cfol_pkg::S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = status.last_stage ? cfol_pkg::S_FREAD : cfol_pkg::S_READ;
         end
         cfol_pkg::S_FREAD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_last = 1'b1;
            state_in    = cfol_pkg::S_FOUT;
         end
         cfol_pkg::S_FOUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = cfol_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfol_pkg::S_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_write_after_mult: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfol_pkg::S_WRITE) |-> ($past(state_ff) == cfol_pkg::S_MULT))
      else $error("stage write without product");
   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfol_pkg::S_DIV && !status.div_done) |=> (state_ff == cfol_pkg::S_DIV))
      else $error("divide left early");
   a_out_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == cfol_pkg::S_IDLE))
      else $error("no return to idle after result");
`endif

endmodule

// ===== rtl/cfol_dp.sv =====
`timescale 1ns / 1ps

module cfol_dp #(
   parameter int MAX_STAGES = cfol_pkg::MAX_STAGES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cfol_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic [cfol_pkg::VALUE_W-1:0]        rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   input  logic [cfol_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cfol_pkg::CSR_DATA_W-1:0]     csr_data,
   input  cfol_pkg::cmd_type                   cmd,
   output cfol_pkg::status_type                status
);

   localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

   // config
   logic [cfol_pkg::ALPHA_W-1:0]  fixed_alpha_ff;
   logic [cfol_pkg::RC_W-1:0]     rc_time_ff;
   logic [cfol_pkg::STAGES_W-1:0] stages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_alpha_ff <= cfol_pkg::ALPHA_ONE;
         rc_time_ff     <= '0;
         stages_ff      <= cfol_pkg::STAGES_W'(1);
      end else if (csr_valid) begin
         unique case (cfol_pkg::csr_index_type'(csr_index))
            cfol_pkg::CSR_FIXED_ALPHA:   fixed_alpha_ff <= csr_data[cfol_pkg::ALPHA_W-1:0];
            cfol_pkg::CSR_RC_TIME_US:    rc_time_ff     <= csr_data[cfol_pkg::RC_W-1:0];
            cfol_pkg::CSR_STAGES_IN_USE: stages_ff      <= csr_data[cfol_pkg::STAGES_W-1:0];
            default: ;
         endcase
      end
   end

   // captured request
   logic                              op_ff;
   logic [cfol_pkg::SAMPLE_W-1:0]     sample_ff;
   logic [cfol_pkg::ELAPSED_W-1:0]    elapsed_ff;
   logic                              wrapped_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser;
         sample_ff  <= req_tdata[15:0];
         elapsed_ff <= req_tdata[39:16];
         wrapped_ff <= req_tdata[40];
      end
   end

   // last active stage
   logic [IDX_W-1:0] last_idx;

   always_comb begin
      priority if (32'(stages_ff) > MAX_STAGES) begin
         last_idx = IDX_W'(MAX_STAGES - 1);
      end else if (stages_ff == '0) begin
         last_idx = '0;
      end else begin
         last_idx = IDX_W'(stages_ff - cfol_pkg::STAGES_W'(1));
      end
   end

   // restoring divider: alpha = (e << 16) / (rc + e), one quotient bit per step
   logic [24:0] rem_ff;
   logic [24:0] den_ff;
   logic [16:0] numlo_ff;
   logic [16:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic [25:0] trial;
   logic        ge;
   logic [25:0] diff_rem;

   assign trial    = {rem_ff, numlo_ff[16]};
   assign ge       = (trial >= {1'b0, den_ff});
   assign diff_rem = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff   <= {2'b00, elapsed_ff[23:1]};
         den_ff   <= {1'b0, rc_time_ff} + {1'b0, elapsed_ff};
         numlo_ff <= {elapsed_ff[0], 16'h0000};
         quo_ff   <= '0;
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff   <= ge ? diff_rem[24:0] : trial[24:0];
         numlo_ff <= {numlo_ff[15:0], 1'b0};
         quo_ff   <= {quo_ff[15:0], ge};
         cnt_ff   <= cnt_ff + 5'd1;
      end
   end

   logic [cfol_pkg::ALPHA_W-1:0] alpha;
   logic                         rc_mode;

   assign rc_mode = (rc_time_ff != '0);

   always_comb begin
      priority if (rc_mode) begin
         alpha = quo_ff;
      end else if (fixed_alpha_ff > cfol_pkg::ALPHA_ONE) begin
         alpha = cfol_pkg::ALPHA_ONE;
      end else begin
         alpha = fixed_alpha_ff;
      end
   end

   // stage store; entries not written since the last load read as base_ff
   logic [cfol_pkg::VALUE_W-1:0] mem [MAX_STAGES];
   logic [MAX_STAGES-1:0]        valid_ff;
   logic [cfol_pkg::VALUE_W-1:0] base_ff;
   logic [cfol_pkg::VALUE_W-1:0] rd_data_ff;
   logic                         rd_valid_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic [IDX_W-1:0]             rd_addr;
   logic [cfol_pkg::VALUE_W-1:0] y_cur;
   logic [cfol_pkg::VALUE_W-1:0] x_ff;
   logic [cfol_pkg::VALUE_W-1:0] y_ff;
   logic signed [50:0]           prod_ff;
   logic signed [32:0]           diff;
   logic signed [17:0]           alpha_s;
   logic signed [50:0]           prod_sh;
   logic [cfol_pkg::VALUE_W-1:0] ny;

   assign rd_addr = cmd.rd_last ? last_idx : idx_ff;
   assign y_cur   = rd_valid_ff ? rd_data_ff : base_ff;
   assign alpha_s = signed'({1'b0, alpha});
   assign diff    = signed'({x_ff[31], x_ff}) - signed'({y_cur[31], y_cur});
   assign prod_sh = prod_ff >>> 16;
   assign ny      = y_ff + prod_sh[31:0];

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[idx_ff] <= ny;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         base_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_all) begin
            valid_ff <= '0;
            base_ff  <= {sample_ff, 16'h0000};
         end else if (cmd.write) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff   <= {req_tdata[15:0], 16'h0000};
         idx_ff <= '0;
      end else if (cmd.write) begin
         x_ff   <= ny;
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.mult) begin
         prod_ff <= alpha_s * diff;
         y_ff    <= y_cur;
      end
   end

   // result register
   logic                         rsp_valid_ff;
   logic [cfol_pkg::VALUE_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= y_cur;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.op_load    = (cfol_pkg::opcode_type'(op_ff) == cfol_pkg::OP_LOAD);
   assign status.rc_mode    = rc_mode;
   assign status.hold       = rc_mode && wrapped_ff;
   assign status.div_done   = (cnt_ff == 5'(cfol_pkg::DIV_STEPS));
   assign status.last_stage = (idx_ff == last_idx);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

`ifndef NO_ASSERTIONS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (idx_ff <= last_idx))
      else $error("stage write beyond active stages");
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");
   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (cnt_ff < 5'(cfol_pkg::DIV_STEPS)))
      else $error("divider stepped too often");
   a_alpha_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mult |-> (alpha <= cfol_pkg::ALPHA_ONE))
      else $error("alpha above one");
`endif

endmodule

// ===== rtl/cascaded_first_order_lowpass_core.sv =====
`timescale 1ns / 1ps

// Chain of first-order low-pass stages (y += alpha*(x - y), Q16.16) sharing one
// multiplier. One request is worked at a time; a finished result sits in the output
// register while the next request is taken. A load or a held request goes from decode
// straight to the read of the last active stage and to the result; a filter request
// first runs one read, multiply and write-back per active stage, preceded in RC mode
// by the restoring divider that forms alpha one quotient bit per cycle. req_tready
// rises in the same cycle as rsp_tvalid, so the next request can be taken at once;
// a result that waits on rsp_tready holds back the next one only when that one is
// ready to leave. Configuration writes are always taken and must only be made while
// the block is idle.
module cascaded_first_order_lowpass_core #(
   parameter int MAX_STAGES = cfol_pkg::MAX_STAGES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cfol_pkg::REQ_DATA_W-1:0]  req_tdata,  // sample[15:0], elapsed_us[39:16],
                                                        // time_wrapped[40]
   input  logic                             req_tuser,  // opcode[0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cfol_pkg::VALUE_W-1:0]     rsp_tdata,  // filtered[31:0]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfol_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cfol_pkg::CSR_DATA_W-1:0]  csr_data
);

   cfol_pkg::cmd_type    cmd;
   cfol_pkg::status_type status;

   assign csr_ready = 1'b1;

   cfol_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfol_dp #(
      .MAX_STAGES (MAX_STAGES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== tb/cascaded_first_order_lowpass_core_test.sv =====
`timescale 1ns / 1ps

module cascaded_first_order_lowpass_core_test;

   localparam int NSTAGE = cfol_pkg::MAX_STAGES_DEFAULT;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_REQUESTS = 100;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      cfol_pkg::csr_index_type idx;
      logic [23:0]             csr_val;
      cfol_pkg::opcode_type    op;
      logic [15:0]             smp;
      logic [23:0]             el;
      logic                    wrap;
      logic                    lit_valid;
      logic [31:0]             lit;
   } stim_row_type;

   typedef struct {
      logic [31:0] filtered;
      int          id;
   } filtered_expect_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [cfol_pkg::REQ_DATA_W-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [cfol_pkg::VALUE_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [cfol_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cfol_pkg::CSR_DATA_W-1:0] csr_data;

   // predictor state and register copies
   logic signed [31:0] stage_val [NSTAGE];
   logic [16:0] alpha_reg;
   logic [23:0] rc_reg;
   logic [3:0]  stages_reg;

   filtered_expect_type pending_filtered [$];
   filtered_expect_type head;
   stim_row_type directed_rows [$];

   int error_count;
   int request_count;
   int load_count;
   int rc_count;
   int held_count;
   int csr_count;
   bit no_idle;

   cascaded_first_order_lowpass_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic logic [31:0] lowpass_step(input cfol_pkg::opcode_type op,
                                               input logic [15:0] smp,
                                               input logic [23:0] el, input logic wrap);
      longint alpha;
      longint x;
      longint y;
      longint ny;
      int n;
      bit hold;
      n = (stages_reg == 0) ? 1 : ((stages_reg > NSTAGE) ? NSTAGE : int'(stages_reg));
      if (op == cfol_pkg::OP_LOAD) begin
         for (int i = 0; i < NSTAGE; i++) stage_val[i] = {smp, 16'h0000};
      end else begin
         hold = 1'b0;
         if (rc_reg != 0) begin
            hold = wrap;
            alpha = longint'({el, 16'h0000}) / (longint'(rc_reg) + longint'(el));
         end else begin
            alpha = (alpha_reg > cfol_pkg::ALPHA_ONE) ? longint'(cfol_pkg::ALPHA_ONE)
                                                      : longint'(alpha_reg);
         end
         if (!hold) begin
            x = longint'($signed(smp)) * 65536;
            for (int i = 0; i < n; i++) begin
               y = longint'(stage_val[i]);
               ny = y + ((alpha * (x - y)) >>> 16);
               stage_val[i] = ny[31:0];
               x = ny;
            end
         end
      end
      return stage_val[n-1];
   endfunction

   function automatic stim_row_type req_row(input cfol_pkg::opcode_type op,
                                            input logic [15:0] smp,
                                            input logic [23:0] el, input logic wrap,
                                            input logic lit_valid, input logic [31:0] lit);
      stim_row_type r;
      r.kind = ROW_REQ;
      r.idx = cfol_pkg::CSR_FIXED_ALPHA;
      r.csr_val = '0;
      r.op = op;
      r.smp = smp;
      r.el = el;
      r.wrap = wrap;
      r.lit_valid = lit_valid;
      r.lit = lit;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input cfol_pkg::csr_index_type idx,
                                            input logic [23:0] val);
      stim_row_type r;
      r = req_row(cfol_pkg::OP_FILTER, '0, '0, 1'b0, 1'b0, '0);
      r.kind = ROW_CSR;
      r.idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   task automatic wait_until_drained();
      while (pending_filtered.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input cfol_pkg::csr_index_type idx, input logic [23:0] val);
      @(negedge clock);
      req_tvalid = 1'b0;
      wait_until_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cfol_pkg::CSR_FIXED_ALPHA:   alpha_reg = val[16:0];
         cfol_pkg::CSR_RC_TIME_US:    rc_reg = val;
         cfol_pkg::CSR_STAGES_IN_USE: stages_reg = val[3:0];
         default: ;
      endcase
      csr_count++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_request(input cfol_pkg::opcode_type op, input logic [15:0] smp,
                               input logic [23:0] el, input logic wrap,
                               input logic lit_valid, input logic [31:0] lit);
      int gap;
      filtered_expect_type e;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {7'b0, wrap, el, smp};
      do @(posedge clock); while (!req_tready);
      if (op == cfol_pkg::OP_LOAD) load_count++;
      else if (rc_reg != 0) begin
         rc_count++;
         if (wrap) held_count++;
      end
      e.filtered = lowpass_step(op, smp, el, wrap);
      if (lit_valid) e.filtered = lit;
      e.id = request_count;
      pending_filtered.push_back(e);
      request_count++;
   endtask

   initial begin : drive_rsp_ready
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_filtered.size() == 0) begin
            report_mismatch($sformatf("unexpected result filtered=%h", rsp_tdata));
         end else begin
            head = pending_filtered.pop_front();
            if (rsp_tdata !== head.filtered)
               report_mismatch($sformatf("request %0d filtered got %h want %h",
                                         head.id, rsp_tdata, head.filtered));
         end
      end
   end

   initial begin : stimulus
      cfol_pkg::opcode_type op;
      logic [15:0] smp;
      logic [23:0] el;
      logic [16:0] a_val;
      logic [23:0] rc_val;
      stim_row_type r;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_idle = 1'b0;
      error_count = 0;
      request_count = 0;
      load_count = 0;
      rc_count = 0;
      held_count = 0;
      csr_count = 0;
      alpha_reg = cfol_pkg::ALPHA_ONE;
      rc_reg = '0;
      stages_reg = 4'd1;
      for (int i = 0; i < NSTAGE; i++) stage_val[i] = '0;

      // state after reset: alpha 1.0, one stage
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h0000, 24'd0, 1'b0, 1'b1,
                                      32'h0000_0000));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd0, 1'b0, 1'b1,
                                      32'h7FFF_0000));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h8000, 24'd0, 1'b0, 1'b1,
                                      32'h8000_0000));
      directed_rows.push_back(req_row(cfol_pkg::OP_LOAD, 16'd12345, 24'd0, 1'b0, 1'b1,
                                      32'h3039_0000));
      // wrap flag ignored in fixed mode
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1,
                                      32'hFFFF_0000));
      directed_rows.push_back(csr_row(cfol_pkg::CSR_FIXED_ALPHA, 24'd0));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd0, 1'b0, 1'b1,
                                      32'hFFFF_0000));
      // alpha above one saturates
      directed_rows.push_back(csr_row(cfol_pkg::CSR_FIXED_ALPHA, 24'h01FFFF));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'd100, 24'd0, 1'b0, 1'b1,
                                      32'h0064_0000));
      directed_rows.push_back(csr_row(cfol_pkg::CSR_FIXED_ALPHA, 24'h008000));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd0, 1'b0, 1'b0, '0));
      // stage count zero acts as one, above bound acts as max
      directed_rows.push_back(csr_row(cfol_pkg::CSR_STAGES_IN_USE, 24'd0));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, -16'sd5000, 24'd0, 1'b0, 1'b0,
                                      '0));
      directed_rows.push_back(csr_row(cfol_pkg::CSR_STAGES_IN_USE, 24'd15));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd0, 1'b0, 1'b0, '0));
      directed_rows.push_back(req_row(cfol_pkg::OP_LOAD, 16'h8000, 24'd0, 1'b0, 1'b1,
                                      32'h8000_0000));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd0, 1'b0, 1'b0, '0));
      // inactive stages keep their values
      directed_rows.push_back(csr_row(cfol_pkg::CSR_STAGES_IN_USE, 24'd3));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h0000, 24'd0, 1'b0, 1'b0, '0));
      // rc mode: zero elapsed, wrap hold, extremes
      directed_rows.push_back(csr_row(cfol_pkg::CSR_RC_TIME_US, 24'd1000));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd0, 1'b0, 1'b0, '0));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd1000, 1'b1, 1'b0,
                                      '0));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'd1000, 1'b0, 1'b0,
                                      '0));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h7FFF, 24'hFFFFFF, 1'b0, 1'b0,
                                      '0));
      directed_rows.push_back(csr_row(cfol_pkg::CSR_RC_TIME_US, 24'hFFFFFF));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h8000, 24'd1, 1'b0, 1'b0, '0));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'h8000, 24'hFFFFFF, 1'b0, 1'b0,
                                      '0));
      // load ignores registers and time inputs
      directed_rows.push_back(req_row(cfol_pkg::OP_LOAD, 16'd7, 24'hABCDEF, 1'b1, 1'b1,
                                      32'h0007_0000));
      directed_rows.push_back(csr_row(cfol_pkg::CSR_STAGES_IN_USE, 24'd8));
      directed_rows.push_back(req_row(cfol_pkg::OP_FILTER, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0,
                                      '0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         r = directed_rows[k];
         if (r.kind == ROW_CSR) write_register(r.idx, r.csr_val);
         else send_request(r.op, r.smp, r.el, r.wrap, r.lit_valid, r.lit);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 4))
            0: a_val = '0;
            1: a_val = cfol_pkg::ALPHA_ONE;
            2: a_val = 17'h1FFFF;
            default: a_val = 17'($urandom_range(0, 65536));
         endcase
         case ($urandom_range(0, 5))
            0, 1: rc_val = '0;
            2: rc_val = 24'd1;
            3: rc_val = 24'hFFFFFF;
            4: rc_val = 24'($urandom_range(1, 5000));
            default: rc_val = 24'($urandom);
         endcase
         write_register(cfol_pkg::CSR_FIXED_ALPHA, {7'b0, a_val});
         write_register(cfol_pkg::CSR_RC_TIME_US, rc_val);
         write_register(cfol_pkg::CSR_STAGES_IN_USE, 24'($urandom_range(0, 15)));
         no_idle = ($urandom_range(0, 3) == 0);
         for (int j = 0; j < PHASE_REQUESTS; j++) begin
            op = ($urandom_range(0, 9) == 0) ? cfol_pkg::OP_LOAD : cfol_pkg::OP_FILTER;
            case ($urandom_range(0, 7))
               0: smp = 16'h7FFF;
               1: smp = 16'h8000;
               default: smp = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: el = 24'($urandom_range(0, 4095));
               1: el = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd0;
               default: el = 24'($urandom);
            endcase
            send_request(op, smp, el, ($urandom_range(0, 5) == 0), 1'b0, '0);
            if ($urandom_range(0, 63) == 0) begin
               @(negedge clock);
               req_tvalid = 1'b0;
               wait_until_drained();
            end
         end
         no_idle = 1'b0;
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      wait_until_drained();
      repeat (64) @(posedge clock);

      $display("ran %0d requests: %0d loads, %0d in rc mode (%0d held on timer wrap)",
               request_count, load_count, rc_count, held_count);
      $display("%0d register writes across fixed and rc modes, %0d mismatches",
               csr_count, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
